### hdl/pns_pkg.sv
`default_nettype none
package pns_pkg;
	localparam int MAX_WAYPOINTS = 1024;
	localparam int COORD_BITS = 24;
	localparam int ADDR_BITS = $clog2(MAX_WAYPOINTS);
	localparam int CNT_BITS = $clog2(MAX_WAYPOINTS + 1);
	localparam int T_FRAC = 24;
	localparam int THR_BITS = 23;
	localparam int DIST_BITS = 25;
	localparam int SEG_BITS = 10;
	localparam int D_BITS = COORD_BITS + 1;
	localparam int SQ_BITS = 2 * D_BITS + 1;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(4096);

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	// Operation codes of the shared arithmetic unit.
	typedef enum logic [1:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		logic [SQ_BITS-1:0] a;
		logic [SQ_BITS-1:0] b;
	} alu_req_t;
endpackage
`default_nettype wire

### hdl/pns_alu.sv
`default_nettype none
// Shared unsigned arithmetic unit with a registered result. Multiplies take
// the low operand halves; add and subtract use the full width.
module pns_alu (
	input  wire logic                         clk,
	input  wire pns_pkg::alu_req_t            req,
	output logic [pns_pkg::SQ_BITS-1:0]       res_q
);
	localparam int HB = pns_pkg::D_BITS;

	always_ff @(posedge clk) begin
		case (req.op)
			pns_pkg::OP_MUL: res_q <= pns_pkg::SQ_BITS'(req.a[HB-1:0] * req.b[HB-1:0]);
			pns_pkg::OP_ADD: res_q <= req.a + req.b;
			pns_pkg::OP_SUB: res_q <= req.a - req.b;
			default:         res_q <= '0;
		endcase
	end
endmodule
`default_nettype wire

### hdl/pns_store.sv
`default_nettype none
// Waypoint memory: one write port, one registered read port.
module pns_store (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic [pns_pkg::ADDR_BITS-1:0]   waddr,
	input  wire logic [2*pns_pkg::COORD_BITS-1:0] wdata,
	input  wire logic [pns_pkg::ADDR_BITS-1:0]   raddr,
	output logic [2*pns_pkg::COORD_BITS-1:0]     rdata_q
);
	logic [2*pns_pkg::COORD_BITS-1:0] mem [pns_pkg::MAX_WAYPOINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/polyline_nearest_segment.sv
`default_nettype none
// Route store with a nearest-segment distance query. A clear or append
// transaction passes through the output state before its result is
// registered. A query first checks the arrival radius against the last
// point, then walks every segment of the route through one shared
// multiply/add unit and a bit-serial divider. A segment whose projection
// clamps to an end point needs two memory reads, the squared length, the dot
// product and the squared distance. Any other segment adds a 24-step division
// for the projection parameter and the projected point. A 26-step square
// root and the output state follow. A route of fewer than two points gives
// a short status instead. The block is not ready while a transaction is in
// progress, and the result register holds until taken.
// Coordinates are signed Q12.12 metres. The stored points are undefined until
// appended, and the route length resets to zero.
module polyline_nearest_segment (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          req_type,
	input  wire logic signed [pns_pkg::COORD_BITS-1:0] pos_x,
	input  wire logic signed [pns_pkg::COORD_BITS-1:0] pos_y,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               status,
	output logic [pns_pkg::DIST_BITS-1:0]            min_distance,
	output logic [pns_pkg::SEG_BITS-1:0]             nearest_segment,
	output logic                                     at_destination,
	output logic [pns_pkg::CNT_BITS-1:0]             point_count,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pns_pkg::THR_BITS-1:0]        cfg_data
);
	localparam int CB = pns_pkg::COORD_BITS;
	localparam int DB = pns_pkg::D_BITS;
	localparam int SB = pns_pkg::SQ_BITS;
	localparam int AB = pns_pkg::ADDR_BITS;
	localparam int TF = pns_pkg::T_FRAC;

	typedef enum logic [4:0] {
		S_IDLE, S_RD0, S_RD1, S_LAST, S_ARR0, S_ARR1, S_ARR2, S_ARR3,
		S_SEG, S_PA, S_PB, S_L0, S_L1, S_D0, S_D1, S_D2,
		S_DIV, S_OFFX, S_OFFY, S_PROJ, S_Q0, S_Q1, S_Q2, S_Q3,
		S_SQRT, S_OUT
	} state_t;

	state_t state_q;
	logic [pns_pkg::THR_BITS-1:0] thr_q;
	logic [pns_pkg::CNT_BITS-1:0] len_q;
	logic signed [CB-1:0] px_q, py_q;
	logic [1:0] req_q;
	logic signed [CB-1:0] sx_q, sy_q;
	logic signed [DB-1:0] ex_q, ey_q, dx_q, dy_q, qx_q, qy_q;
	logic [SB-1:0] acc_q, len2_q, pos_q, neg_q, best_q, rem_q;
	logic [TF-1:0] t_q;
	logic [5:0] step_q;
	logic [AB-1:0] seg_q, bseg_q, raddr_q;
	logic mode_q;
	logic [SB-1:0] sq_v_q, sq_r_q, sq_b_q;

	pns_pkg::alu_req_t alu_req;
	logic [SB-1:0] alu_res;
	logic [2*CB-1:0] rdata;
	logic we;

	pns_alu u_alu (.clk(clk), .req(alu_req), .res_q(alu_res));

	assign we = in_valid && in_ready && (req_type == pns_pkg::REQ_APPEND)
		&& (len_q < pns_pkg::CNT_BITS'(pns_pkg::MAX_WAYPOINTS));
	pns_store u_store (
		.clk(clk), .we(we), .waddr(len_q[AB-1:0]), .wdata({pos_x, pos_y}),
		.raddr(raddr_q), .rdata_q(rdata)
	);

	logic signed [CB-1:0] rx, ry;
	assign rx = rdata[2*CB-1:CB];
	assign ry = rdata[CB-1:0];

	function automatic logic [SB-1:0] mg(input logic signed [DB-1:0] v);
		mg = v[DB-1] ? SB'(-v) : SB'(v);
	endfunction

	// Arithmetic requests follow the state.
	always_comb begin
		alu_req = '{op: pns_pkg::OP_ADD, a: '0, b: '0};
		case (state_q)
			S_ARR0: alu_req = '{op: pns_pkg::OP_MUL, a: mg(dx_q), b: mg(dx_q)};
			S_ARR1: alu_req = '{op: pns_pkg::OP_MUL, a: mg(dy_q), b: mg(dy_q)};
			S_PB: alu_req = '{op: pns_pkg::OP_MUL, a: mg(ey_q), b: mg(ey_q)};
			S_Q1: begin
				if (step_q == 6'd0) alu_req = '{op: pns_pkg::OP_MUL, a: mg(dx_q), b: mg(dx_q)};
				else alu_req = '{op: pns_pkg::OP_MUL, a: mg(dy_q), b: mg(dy_q)};
			end
			S_ARR2, S_L1, S_Q2: alu_req = '{op: pns_pkg::OP_ADD, a: acc_q, b: alu_res};
			S_ARR3: alu_req = '{op: pns_pkg::OP_MUL, a: SB'(thr_q), b: SB'(thr_q)};
			S_L0: alu_req = '{op: pns_pkg::OP_MUL, a: mg(DB'(ex_q)), b: mg(DB'(ex_q))};
			S_D0: alu_req = '{op: pns_pkg::OP_MUL, a: mg(dx_q), b: mg(DB'(ex_q))};
			S_D1: alu_req = '{op: pns_pkg::OP_MUL, a: mg(dy_q), b: mg(DB'(ey_q))};
			S_OFFX: alu_req = '{op: pns_pkg::OP_MUL, a: SB'(t_q), b: mg(DB'(ex_q))};
			S_OFFY: alu_req = '{op: pns_pkg::OP_MUL, a: SB'(t_q), b: mg(DB'(ey_q))};
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign cfg_ready = 1'b1;

	logic [SB-1:0] sq_try;
	assign sq_try = sq_r_q + sq_b_q;
	logic [SB-1:0] rsh;
	assign rsh = {rem_q[SB-2:0], 1'b0};
	logic [SB-1:0] offr;
	assign offr = alu_res + (SB'(1) << (TF - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			thr_q <= pns_pkg::THR_RESET;
			len_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= req_type;
						px_q <= pos_x;
						py_q <= pos_y;
						status <= (req_type == pns_pkg::REQ_APPEND && !we)
							? pns_pkg::ST_FULL : pns_pkg::ST_OK;
						min_distance <= '0;
						nearest_segment <= '0;
						at_destination <= 1'b0;
						raddr_q <= AB'(len_q - 1'b1);
						if (req_type == pns_pkg::REQ_CLEAR) begin
							len_q <= '0;
							state_q <= S_OUT;
						end else if (req_type == pns_pkg::REQ_APPEND) begin
							if (we) len_q <= len_q + 1'b1;
							state_q <= S_OUT;
						end else if (req_type == pns_pkg::REQ_QUERY) begin
							state_q <= (len_q == '0) ? S_LAST : S_RD0;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					dx_q <= DB'(px_q) - DB'(rx);
					dy_q <= DB'(py_q) - DB'(ry);
					state_q <= S_ARR0;
				end
				S_ARR0: state_q <= S_ARR1;
				S_ARR1: begin
					acc_q <= alu_res;
					state_q <= S_ARR2;
				end
				S_ARR2: state_q <= S_ARR3;
				S_ARR3: begin
					acc_q <= alu_res;
					state_q <= S_LAST;
					mode_q <= 1'b1;
				end
				S_LAST: begin
					// Threshold product is ready here when the route is nonempty.
					if (len_q != '0 && mode_q) at_destination <= (acc_q < alu_res);
					mode_q <= 1'b0;
					if (len_q < pns_pkg::CNT_BITS'(2)) begin
						status <= pns_pkg::ST_SHORT;
						state_q <= S_OUT;
					end else begin
						seg_q <= '0;
						raddr_q <= '0;
						state_q <= S_SEG;
						step_q <= '0;
					end
				end
				S_SEG: begin
					// Read start then end point of the segment.
					step_q <= step_q + 1'b1;
					if (step_q == 6'd0) begin
						raddr_q <= seg_q + 1'b1;
					end else if (step_q == 6'd1) begin
						sx_q <= rx;
						sy_q <= ry;
						dx_q <= DB'(px_q) - DB'(rx);
						dy_q <= DB'(py_q) - DB'(ry);
					end else begin
						ex_q <= DB'(rx) - DB'(sx_q);
						ey_q <= DB'(ry) - DB'(sy_q);
						state_q <= S_L0;
					end
				end
				S_L0: state_q <= S_PA;
				S_PA: begin
					acc_q <= alu_res;
					state_q <= S_PB;
				end
				S_PB: state_q <= S_L1;
				S_L1: state_q <= S_D0;
				S_D0: begin
					len2_q <= alu_res;
					state_q <= S_D1;
				end
				S_D1: begin
					if (dx_q[DB-1] != ex_q[DB-1]) begin
						pos_q <= '0;
						neg_q <= alu_res;
					end else begin
						pos_q <= alu_res;
						neg_q <= '0;
					end
					state_q <= S_D2;
				end
				S_D2: begin
					logic [SB-1:0] np, nn;
					np = pos_q;
					nn = neg_q;
					if ((dy_q[DB-1]) != ey_q[DB-1]) nn = nn + alu_res;
					else np = np + alu_res;
					if (len2_q == '0 || np <= nn) begin
						qx_q <= DB'(sx_q);
						qy_q <= DB'(sy_q);
						state_q <= S_Q0;
					end else if (np - nn >= len2_q) begin
						qx_q <= DB'(sx_q) + DB'(ex_q);
						qy_q <= DB'(sy_q) + DB'(ey_q);
						state_q <= S_Q0;
					end else begin
						rem_q <= np - nn;
						t_q <= '0;
						step_q <= '0;
						state_q <= S_DIV;
					end
					dx_q <= DB'(px_q);
					dy_q <= DB'(py_q);
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (rsh >= len2_q) begin
						rem_q <= rsh - len2_q;
						t_q <= {t_q[TF-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						t_q <= {t_q[TF-2:0], 1'b0};
					end
					if (step_q == 6'(TF - 1)) state_q <= S_OFFX;
				end
				S_OFFX: state_q <= S_OFFY;
				S_OFFY: begin
					qx_q <= ex_q[DB-1] ? DB'(sx_q) - DB'(offr >> TF)
						: DB'(sx_q) + DB'(offr >> TF);
					state_q <= S_PROJ;
				end
				S_PROJ: begin
					qy_q <= ey_q[DB-1] ? DB'(sy_q) - DB'(offr >> TF)
						: DB'(sy_q) + DB'(offr >> TF);
					state_q <= S_Q0;
				end
				S_Q0: begin
					// Reuse dx/dy as the offset to the projected point.
					dx_q <= dx_q - qx_q;
					dy_q <= dy_q - qy_q;
					state_q <= S_Q1;
					step_q <= '0;
				end
				S_Q1: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd1) acc_q <= alu_res;
					if (step_q == 6'd2) state_q <= S_Q2;
				end
				S_Q2: state_q <= S_Q3;
				S_Q3: begin
					if (seg_q == '0 || alu_res < best_q) begin
						best_q <= alu_res;
						bseg_q <= seg_q;
					end
					if (pns_pkg::CNT_BITS'(seg_q) + 2'd2 >= len_q) begin
						state_q <= S_SQRT;
						step_q <= '0;
						sq_r_q <= '0;
						sq_b_q <= SB'(1) << (SB - 1 - ((SB - 1) % 2));
						sq_v_q <= (seg_q == '0 || alu_res < best_q) ? alu_res : best_q;
						nearest_segment <= pns_pkg::SEG_BITS'((seg_q == '0 || alu_res < best_q)
							? seg_q : bseg_q);
					end else begin
						seg_q <= seg_q + 1'b1;
						raddr_q <= seg_q + 1'b1;
						step_q <= '0;
						state_q <= S_SEG;
					end
				end
				S_SQRT: begin
					// One result bit per cycle.
					if (sq_v_q >= sq_try) begin
						sq_v_q <= sq_v_q - sq_try;
						sq_r_q <= (sq_r_q >> 1) + sq_b_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_b_q <= sq_b_q >> 2;
					if (sq_b_q == SB'(1)) state_q <= S_OUT;
				end
				S_OUT: begin
					if (req_q == pns_pkg::REQ_QUERY && status == pns_pkg::ST_OK) begin
						min_distance <= (sq_r_q > SB'(pns_pkg::DIST_MAX))
							? pns_pkg::DIST_MAX : pns_pkg::DIST_BITS'(sq_r_q);
					end
					point_count <= len_q;
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/polyline_nearest_segment_chk.sv
`default_nettype none
// Port-level checks of the route block.
module polyline_nearest_segment_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] status,
	input wire logic [pns_pkg::DIST_BITS-1:0] min_distance,
	input wire logic [pns_pkg::CNT_BITS-1:0] point_count
);
	// A result that waits is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_distance))
		else $error("result changed while stalled");
	// No new transaction is taken while a result waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during pending result");
	// A short route never reports a distance.
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pns_pkg::ST_SHORT |-> min_distance == '0)
		else $error("distance on short route");
	// Point count never exceeds capacity.
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> point_count <= pns_pkg::CNT_BITS'(pns_pkg::MAX_WAYPOINTS))
		else $error("point count out of range");
endmodule

bind polyline_nearest_segment polyline_nearest_segment_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.min_distance(min_distance), .point_count(point_count)
);
`default_nettype wire

### dv/tb.sv
`default_nettype none

// Predicts each result of the route store and checks it against the block.
class nav_scoreboard;
	localparam int DEPTH = pns_pkg::MAX_WAYPOINTS;

	typedef struct {
		logic [1:0]                    status;
		logic [pns_pkg::DIST_BITS-1:0] min_distance;
		logic [pns_pkg::SEG_BITS-1:0]  nearest_segment;
		logic                          at_destination;
		logic [pns_pkg::CNT_BITS-1:0]  point_count;
	} nav_result_t;

	longint       way_x[DEPTH];
	longint       way_y[DEPTH];
	int           way_count;
	bit [63:0]    arrive_radius;
	nav_result_t  expected_results[$];
	int           mismatches;

	function new();
		way_count = 0;
		arrive_radius = 64'(pns_pkg::THR_RESET);
		mismatches = 0;
	endfunction

	function void set_radius(logic [pns_pkg::THR_BITS-1:0] value);
		arrive_radius = 64'(value);
	endfunction

	function bit [63:0] magnitude(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function bit [63:0] span2(longint ax, longint ay, longint bx, longint by);
		bit [63:0] mx;
		bit [63:0] my;
		mx = magnitude(bx - ax);
		my = magnitude(by - ay);
		return mx * mx + my * my;
	endfunction

	// Moves from start along delta by the fraction t (Q0.24), rounding halves away.
	function longint step_along(longint start, longint delta, bit [63:0] t);
		bit [63:0] off;
		off = (t * magnitude(delta) + (64'd1 << 23)) >> 24;
		return (delta < 0) ? start - longint'(off) : start + longint'(off);
	endfunction

	// Squared distance from a position to segment s, with the projection clamped.
	function bit [63:0] segment_span2(int s, longint qx, longint qy);
		longint    sx, sy, ex, ey, dx, dy;
		bit [63:0] len2, pos, neg, p, dotm, r, t;
		sx = way_x[s];
		sy = way_y[s];
		ex = way_x[s+1] - sx;
		ey = way_y[s+1] - sy;
		dx = qx - sx;
		dy = qy - sy;
		len2 = span2(0, 0, ex, ey);
		pos = 0;
		neg = 0;
		if (len2 == 0)
			return span2(sx, sy, qx, qy);
		p = magnitude(dx) * magnitude(ex);
		if ((dx < 0) != (ex < 0)) neg += p; else pos += p;
		p = magnitude(dy) * magnitude(ey);
		if ((dy < 0) != (ey < 0)) neg += p; else pos += p;
		if (pos <= neg)
			return span2(sx, sy, qx, qy);
		dotm = pos - neg;
		if (dotm >= len2)
			return span2(way_x[s+1], way_y[s+1], qx, qy);
		r = dotm;
		t = 0;
		for (int i = 0; i < 24; i++) begin
			r = r << 1;
			t = t << 1;
			if (r >= len2) begin
				r -= len2;
				t |= 1;
			end
		end
		return span2(qx, qy, step_along(sx, ex, t), step_along(sy, ey, t));
	endfunction

	function bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Called for every accepted request: updates the route and queues the result.
	function void note_request(logic [1:0] req, logic signed [23:0] x, logic signed [23:0] y);
		nav_result_t r;
		longint      qx, qy;
		bit [63:0]   best, d;
		int          seg;
		qx = longint'(x);
		qy = longint'(y);
		r = '{default: '0};
		best = 0;
		seg = 0;
		case (req)
			pns_pkg::REQ_CLEAR: begin
				way_count = 0;
			end
			pns_pkg::REQ_APPEND: begin
				if (way_count < DEPTH) begin
					way_x[way_count] = qx;
					way_y[way_count] = qy;
					way_count++;
				end else begin
					r.status = pns_pkg::ST_FULL;
				end
			end
			pns_pkg::REQ_QUERY: begin
				if (way_count >= 1 && span2(qx, qy, way_x[way_count-1], way_y[way_count-1])
						< arrive_radius * arrive_radius)
					r.at_destination = 1'b1;
				if (way_count < 2) begin
					r.status = pns_pkg::ST_SHORT;
				end else begin
					for (int s = 0; s + 1 < way_count; s++) begin
						d = segment_span2(s, qx, qy);
						if (s == 0 || d < best) begin
							best = d;
							seg = s;
						end
					end
					d = int_sqrt(best);
					if (d > 64'(pns_pkg::DIST_MAX)) d = 64'(pns_pkg::DIST_MAX);
					r.min_distance = d[pns_pkg::DIST_BITS-1:0];
					r.nearest_segment = seg[pns_pkg::SEG_BITS-1:0];
				end
			end
			default: ;
		endcase
		r.point_count = way_count[pns_pkg::CNT_BITS-1:0];
		expected_results = {expected_results, r};
	endfunction

	function void check_result(nav_result_t got);
		nav_result_t want;
		if (expected_results.size() == 0) begin
			$error("result arrived with no request outstanding");
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			mismatches++;
		end
		if (got.min_distance !== want.min_distance) begin
			$error("min_distance: expected %0d, got %0d", want.min_distance, got.min_distance);
			mismatches++;
		end
		if (got.nearest_segment !== want.nearest_segment) begin
			$error("nearest_segment: expected %0d, got %0d",
				want.nearest_segment, got.nearest_segment);
			mismatches++;
		end
		if (got.at_destination !== want.at_destination) begin
			$error("at_destination: expected %0d, got %0d",
				want.at_destination, got.at_destination);
			mismatches++;
		end
		if (got.point_count !== want.point_count) begin
			$error("point_count: expected %0d, got %0d", want.point_count, got.point_count);
			mismatches++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 300000;
	localparam longint M = 4096;

	logic                                   clk;
	logic                                   arst_n;
	logic                                   in_valid;
	logic                                   in_ready;
	logic [1:0]                             req_type;
	logic signed [pns_pkg::COORD_BITS-1:0]  pos_x;
	logic signed [pns_pkg::COORD_BITS-1:0]  pos_y;
	logic                                   out_valid;
	logic                                   out_ready;
	logic [1:0]                             status;
	logic [pns_pkg::DIST_BITS-1:0]          min_distance;
	logic [pns_pkg::SEG_BITS-1:0]           nearest_segment;
	logic                                   at_destination;
	logic [pns_pkg::CNT_BITS-1:0]           point_count;
	logic                                   cfg_valid;
	logic                                   cfg_ready;
	logic [pns_pkg::THR_BITS-1:0]           cfg_data;

	nav_scoreboard board = new();
	int burst_left = 0;
	bit gaps_on = 1;
	int idle_cycles = 0;
	int ready_mode = 0;
	int ready_tick = 0;

	polyline_nearest_segment u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .min_distance(min_distance), .nearest_segment(nearest_segment),
		.at_destination(at_destination), .point_count(point_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Receiver: switches among always-ready, random and periodic stall patterns.
	always @(negedge clk) begin
		ready_tick++;
		if (ready_tick % 64 == 0) ready_mode = $urandom_range(0, 2);
		case (ready_mode)
			0: out_ready = 1'b1;
			1: out_ready = 1'($urandom_range(0, 1));
			default: out_ready = (ready_tick % 7) < 4;
		endcase
	end

	// Check each result transaction and watch for a hung block.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result('{status, min_distance, nearest_segment, at_destination,
				point_count});
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("polyline_nearest_segment regression: fail");
			$finish;
		end
	end

	// Issues one request transaction; starts and ends at a falling edge.
	task automatic send_request(logic [1:0] req, longint x, longint y);
		if (gaps_on) begin
			if (burst_left == 0) begin
				repeat ($urandom_range(0, 12)) @(negedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		in_valid = 1'b1;
		req_type = req;
		pos_x = 24'(x);
		pos_y = 24'(y);
		do @(posedge clk); while (!in_ready);
		board.note_request(req, 24'(x), 24'(y));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Waits for every result to drain, then writes the arrival radius.
	task automatic write_radius(logic [pns_pkg::THR_BITS-1:0] value);
		wait (board.expected_results.size() == 0);
		repeat (8) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		board.set_radius(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic longint any_coord();
		return longint'($signed(24'($urandom)));
	endfunction

	function automatic longint near_coord(longint c);
		longint v;
		v = c + longint'($urandom_range(0, 32'(16 * M))) - 8 * M;
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v;
	endfunction

	initial begin
		int n;
		int k;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = pns_pkg::REQ_CLEAR;
		pos_x = '0;
		pos_y = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: short routes, unused code, zero-length segment, ties, extremes.
		send_request(pns_pkg::REQ_QUERY, 0, 0);
		send_request(pns_pkg::REQ_APPEND, 0, 0);
		send_request(pns_pkg::REQ_QUERY, 100, -100);
		send_request(REQ_UNUSED, -1, -1);
		send_request(pns_pkg::REQ_APPEND, 4 * M, 0);
		send_request(pns_pkg::REQ_APPEND, 4 * M, 0);
		send_request(pns_pkg::REQ_APPEND, 4 * M, 4 * M);
		send_request(pns_pkg::REQ_QUERY, -M, M);
		send_request(pns_pkg::REQ_QUERY, 2 * M + 3, M - 7);
		send_request(pns_pkg::REQ_QUERY, 5 * M, 6 * M);
		send_request(pns_pkg::REQ_QUERY, 4 * M, 0);
		send_request(pns_pkg::REQ_QUERY, 4 * M + 100, 4 * M - 50);
		send_request(pns_pkg::REQ_APPEND, 8388607, 8388607);
		send_request(pns_pkg::REQ_QUERY, -8388608, -8388608);
		send_request(pns_pkg::REQ_QUERY, 8388607, -8388608);
		write_radius('1);
		send_request(pns_pkg::REQ_QUERY, -8388608, 8388607);
		write_radius('0);
		send_request(pns_pkg::REQ_QUERY, 8388607, 8388607);
		send_request(pns_pkg::REQ_CLEAR, 0, 0);
		send_request(pns_pkg::REQ_QUERY, 0, 0);
		write_radius(pns_pkg::THR_RESET);

		// Random: build short routes and query around them, with some noise.
		n = 0;
		while (n < 80) begin
			pick = $urandom_range(0, 3);
			if (pick == 0)
				write_radius(pns_pkg::THR_BITS'($urandom_range(0, 32'(16 * M))));
			else if (pick == 1)
				write_radius(pns_pkg::THR_BITS'($urandom));
			gaps_on = $urandom_range(0, 3) != 0;
			send_request(pns_pkg::REQ_CLEAR, any_coord(), any_coord());
			k = $urandom_range(1, 8);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(0, 5) == 0)
					send_request(pns_pkg::REQ_APPEND, any_coord(), any_coord());
				else if ($urandom_range(0, 6) == 0 && i > 0)
					send_request(pns_pkg::REQ_APPEND, board.way_x[i-1], board.way_y[i-1]);
				else
					send_request(pns_pkg::REQ_APPEND, near_coord(i * 8 * M), near_coord(0));
				n++;
			end
			repeat ($urandom_range(2, 6)) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					send_request(REQ_UNUSED, any_coord(), any_coord());
				else if (pick == 1)
					send_request(pns_pkg::REQ_QUERY, any_coord(), any_coord());
				else
					send_request(pns_pkg::REQ_QUERY,
						near_coord(board.way_x[board.way_count-1]),
						near_coord(board.way_y[board.way_count-1] + 2 * M));
				n++;
			end
		end

		wait (board.expected_results.size() == 0);
		repeat (50) @(posedge clk);
		if (board.mismatches == 0)
			$display("polyline_nearest_segment regression: pass");
		else
			$display("polyline_nearest_segment regression: fail");
		$finish;
	end
endmodule

`default_nettype wire

### polyline_nearest_segment.f
hdl/pns_pkg.sv
hdl/pns_alu.sv
hdl/pns_store.sv
hdl/polyline_nearest_segment.sv
hdl/polyline_nearest_segment_chk.sv
dv/tb.sv
